@@ rtl/mf3_pkg.sv @@
// ----------------------------------------------------------------------------
// mf3_pkg
// shared types and constants of the 3x3 median filter: pixel layout, the
// nine-value sets handled by the sorting network, config register indexes
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int CHANNELS   = 3;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = CHANNELS * CHAN_W;
  localparam int TAPS       = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  // reset values of the dimension registers
  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;
  // smallest frame dimension the filter handles
  localparam int DIM_MIN    = 3;

  typedef logic [CHAN_W-1:0] chan_t;
  // channel 0 in the lowest byte
  typedef chan_t [CHANNELS-1:0] pix_t;
  // 3x3 neighborhood, row-major from the top left
  typedef pix_t [TAPS-1:0] win_t;
  // one channel of a neighborhood
  typedef chan_t [TAPS-1:0] chan9_t;
  typedef chan9_t [CHANNELS-1:0] set3_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

endpackage

@@ rtl/mf3_ram.sv @@
// ----------------------------------------------------------------------------
// mf3_ram
// simple dual-port ram, one write and one read port, registered read;
// a read of the address being written returns the old contents
// ----------------------------------------------------------------------------
module mf3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mf3_median.sv @@
// ----------------------------------------------------------------------------
// mf3_median
// three-stage per-channel median of nine: input register, first half of the
// sorting network, second half into the output register
// ----------------------------------------------------------------------------
module mf3_median (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mf3_pkg::win_t   in_win,
  input  logic            in_last,
  output logic            out_valid,
  input  logic            out_ready,
  output mf3_pkg::pix_t   out_pix,
  output logic            out_last
);

  import mf3_pkg::*;

  // compare and exchange, smaller value ends at position a
  function automatic chan9_t cmp_swap(input chan9_t v, input int a, input int b);
    chan9_t r;
    r = v;
    if (v[a] > v[b]) begin
      r[a] = v[b];
      r[b] = v[a];
    end
    return r;
  endfunction

  // sort the three triples, then the first merge layer
  function automatic chan9_t med_front(input chan9_t p);
    chan9_t v;
    v = p;
    v = cmp_swap(v, 1, 2);
    v = cmp_swap(v, 4, 5);
    v = cmp_swap(v, 7, 8);
    v = cmp_swap(v, 0, 1);
    v = cmp_swap(v, 3, 4);
    v = cmp_swap(v, 6, 7);
    v = cmp_swap(v, 1, 2);
    v = cmp_swap(v, 4, 5);
    v = cmp_swap(v, 7, 8);
    v = cmp_swap(v, 0, 3);
    v = cmp_swap(v, 5, 8);
    v = cmp_swap(v, 4, 7);
    return v;
  endfunction

  // remaining exchanges, median lands at position 4
  function automatic chan_t med_back(input chan9_t p);
    chan9_t v;
    v = p;
    v = cmp_swap(v, 3, 6);
    v = cmp_swap(v, 1, 4);
    v = cmp_swap(v, 2, 5);
    v = cmp_swap(v, 4, 7);
    v = cmp_swap(v, 4, 2);
    v = cmp_swap(v, 6, 4);
    v = cmp_swap(v, 4, 2);
    return v[4];
  endfunction

  logic  c_valid, d_valid, e_valid;
  win_t  c_win;
  logic  c_last, d_last, e_last;
  set3_t d_part;
  pix_t  e_pix;

  set3_t c_set, d_next;
  pix_t  e_next;
  logic  rdy_c, rdy_d, rdy_e;

  assign rdy_e    = !e_valid || out_ready;
  assign rdy_d    = !d_valid || rdy_e;
  assign rdy_c    = !c_valid || rdy_d;
  assign in_ready = rdy_c;

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int i = 0; i < TAPS; i++) begin
        c_set[ch][i] = c_win[i][ch];
      end
      d_next[ch] = med_front(c_set[ch]);
      e_next[ch] = med_back(d_part[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      if (rdy_c) begin
        c_valid <= in_valid;
      end
      if (rdy_d) begin
        d_valid <= c_valid;
      end
      if (rdy_e) begin
        e_valid <= d_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && in_valid) begin
      c_win  <= in_win;
      c_last <= in_last;
    end
    if (rdy_d && c_valid) begin
      d_part <= d_next;
      d_last <= c_last;
    end
    if (rdy_e && d_valid) begin
      e_pix  <= e_next;
      e_last <= d_last;
    end
  end

  assign out_valid = e_valid;
  assign out_pix   = e_pix;
  assign out_last  = e_last;

endmodule

@@ rtl/median3x3_rgb_filter_core.sv @@
// ----------------------------------------------------------------------------
// median3x3_rgb_filter_core
// 3x3 median filter for 3-channel 8-bit pixels in raster order, with two
// line stores in block ram and a 3x2 column window in registers
//
//   channel | direction | signals                        | transaction
//   --------+-----------+--------------------------------+-------------------
//   s_*     | in        | tvalid tready tdata tuser      | one pixel or flush
//   m_*     | out       | tvalid tready tdata tlast      | one filtered pixel
//   cfg_*   | in        | valid ready index data         | one register write
//
// one pixel per clock sustained while m_* does not stall; the result for the
// transaction that completes a neighborhood passes the ram stage and the median
// stages to the output; line stores are read on accept and written as the item
// leaves the ram stage; a read of the column being written takes forwarded data
// reset (synchronous) clears position, window and stage valids and loads the
// reset dimensions; the line stores need no clearing pass
// a stall on m_* fills the pipeline bubbles first, then holds s_tready low
// ----------------------------------------------------------------------------
module median3x3_rgb_filter_core #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  // pixel in
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mf3_pkg::PIX_W-1:0]           s_tdata,   // chan0_in, chan1_in, chan2_in
  input  logic [0:0]                          s_tuser,   // flush
  // pixel out
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mf3_pkg::PIX_W-1:0]           m_tdata,   // chan0_out, chan1_out, chan2_out
  output logic                                m_tlast,   // frame_last
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import mf3_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);       // column index, ram address
  localparam int WD_W  = $clog2(MAX_WIDTH + 1);   // clamped width
  localparam int HD_W  = $clog2(MAX_HEIGHT + 1);  // clamped height
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);  // row runs up to height+1
  localparam int CW_W  = (CFG_DATA_W > WD_W) ? CFG_DATA_W : WD_W;
  localparam int CH_W  = (CFG_DATA_W > HD_W) ? CFG_DATA_W : HD_W;

  // clamped reset dimensions
  localparam int W_RST = (WIDTH_RST < DIM_MIN) ? DIM_MIN :
                         ((WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST);
  localparam int H_RST = (HEIGHT_RST < DIM_MIN) ? DIM_MIN :
                         ((HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST);

  // registers are kept already clamped into their legal range
  function automatic logic [WD_W-1:0] clamp_w(input logic [CFG_DATA_W-1:0] v);
    logic [CW_W-1:0] ve;
    ve = CW_W'(v);
    if (ve < CW_W'(DIM_MIN)) begin
      return WD_W'(DIM_MIN);
    end else if (ve > CW_W'(MAX_WIDTH)) begin
      return WD_W'(MAX_WIDTH);
    end
    return WD_W'(ve);
  endfunction

  function automatic logic [HD_W-1:0] clamp_h(input logic [CFG_DATA_W-1:0] v);
    logic [CH_W-1:0] ve;
    ve = CH_W'(v);
    if (ve < CH_W'(DIM_MIN)) begin
      return HD_W'(DIM_MIN);
    end else if (ve > CH_W'(MAX_HEIGHT)) begin
      return HD_W'(MAX_HEIGHT);
    end
    return HD_W'(ve);
  endfunction

  // configuration
  logic [WD_W-1:0]  width;
  logic [HD_W-1:0]  height;

  // frame position of the next pixel
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             primed;

  // ram stage: the item whose line store data arrives this cycle
  logic             b_valid;
  logic [COL_W-1:0] b_col;
  pix_t             b_pix;
  logic             b_res;     // item yields a result
  logic             b_inner;   // result is an interior median
  logic             b_last;
  logic             b_fwd;     // read overlapped the write of the same column
  pix_t             b_fwd_top;
  pix_t             b_fwd_mid;

  // window: [0..2] older column top/mid/bottom, [3..5] newer column
  pix_t [5:0]       win;

  logic             flush, drain, ends, drop;
  logic             accept, load_b, b_move, fwd_hit;
  logic             col_wrap;
  pix_t             pix_in;
  logic             inner;
  pix_t             upper_q, middle_q, top_eff, mid_eff;
  logic             med_ready;
  win_t             med_win;
  pix_t             out_pix;

  // no transaction is taken while reset is held
  assign cfg_ready = !rst;

  // item classification against the current frame position
  assign flush  = s_tuser[0];
  assign drain  = row >= ROW_W'(height);
  assign ends   = row >= (ROW_W'(height) + ROW_W'(1));
  assign drop   = !drain && flush;   // stray flush: no result, no state change
  assign pix_in = drain ? '0 : pix_t'(s_tdata);

  // interior when the output position sits off every border
  assign inner = (col >= COL_W'(2)) && (WD_W'(col) < width) &&
                 (row >= ROW_W'(2)) && (row < ROW_W'(height));

  assign col_wrap = (WD_W'(col) + WD_W'(1)) >= width;

  // pipeline control
  assign b_move   = b_valid && (!b_res || med_ready);
  assign s_tready = !rst && (!b_valid || b_move);
  assign accept   = s_tvalid && s_tready;
  assign load_b   = accept && !drop;
  assign fwd_hit  = b_move && (b_col == col);

  // line store data, forwarded when the previous item just wrote this column
  assign top_eff = b_fwd ? b_fwd_top : upper_q;
  assign mid_eff = b_fwd ? b_fwd_mid : middle_q;

  mf3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (b_move),
    .waddr (b_col),
    .wdata (mid_eff),
    .re    (load_b),
    .raddr (col),
    .rdata (upper_q)
  );

  mf3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk   (clk),
    .we    (b_move),
    .waddr (b_col),
    .wdata (b_pix),
    .re    (load_b),
    .raddr (col),
    .rdata (middle_q)
  );

  // neighborhood for the sorting network; a border pixel is copied by
  // giving all nine taps the center value
  always_comb begin
    if (b_inner) begin
      med_win[0] = win[0];
      med_win[1] = win[3];
      med_win[2] = top_eff;
      med_win[3] = win[1];
      med_win[4] = win[4];
      med_win[5] = mid_eff;
      med_win[6] = win[2];
      med_win[7] = win[5];
      med_win[8] = b_pix;
    end else begin
      for (int i = 0; i < TAPS; i++) begin
        med_win[i] = win[4];
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      width   <= WD_W'(W_RST);
      height  <= HD_W'(H_RST);
      col     <= '0;
      row     <= '0;
      primed  <= 1'b0;
      b_valid <= 1'b0;
      win     <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH: begin
            width <= clamp_w(cfg_data);
          end
          CFG_IMAGE_HEIGHT: begin
            height <= clamp_h(cfg_data);
          end
          default: begin
          end
        endcase
      end

      if (load_b) begin
        b_valid <= 1'b1;
      end else if (b_move) begin
        b_valid <= 1'b0;
      end

      if (load_b) begin
        if (ends) begin
          col    <= '0;
          row    <= '0;
          primed <= 1'b0;
        end else begin
          // output pipeline fills once the first pixel of row one arrives
          if ((row == ROW_W'(1)) && (col == '0)) begin
            primed <= 1'b1;
          end
          if (col_wrap) begin
            col <= '0;
            row <= row + ROW_W'(1);
          end else begin
            col <= col + COL_W'(1);
          end
        end
      end

      // window shifts as the item leaves the ram stage
      if (b_move) begin
        win[0] <= win[3];
        win[1] <= win[4];
        win[2] <= win[5];
        win[3] <= top_eff;
        win[4] <= mid_eff;
        win[5] <= b_pix;
      end
    end
  end

  // ram stage payload
  always_ff @(posedge clk) begin
    if (load_b) begin
      b_col     <= col;
      b_pix     <= pix_in;
      b_res     <= primed;
      b_inner   <= inner;
      b_last    <= ends;
      b_fwd     <= fwd_hit;
      b_fwd_top <= mid_eff;
      b_fwd_mid <= b_pix;
    end
  end

  mf3_median u_median (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid && b_res),
    .in_ready  (med_ready),
    .in_win    (med_win),
    .in_last   (b_last),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pix   (out_pix),
    .out_last  (m_tlast)
  );

  assign m_tdata = PIX_W'(out_pix);

endmodule
